[src/lob_pkg.sv]
// Package for the limit order book: command and status codes, sizes and
// shared types. No dependencies.
package lob_pkg;

  localparam int MAX_ORDERS_DEFAULT = 256;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_CANCEL = 3'd1;
  localparam logic [2:0] CMD_MODIFY = 3'd2;
  localparam logic [2:0] CMD_POP    = 3'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_DUP       = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
  } lob_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] popped_id;
    logic        popped_side;
    logic [31:0] popped_price;
    logic [31:0] popped_remaining;
    logic        top_bid_valid;
    logic [31:0] top_bid;
    logic        top_ask_valid;
    logic [31:0] top_ask;
    logic [39:0] bid_volume;
    logic [39:0] ask_volume;
  } lob_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input transaction
    logic scan_start; // clear scan results, start at slot zero
    logic scan_step;  // examine one slot
    logic commit;     // apply the command from the scan results
    logic report;     // capture the result
  } lob_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // slot being examined is the last one
  } lob_stat_t;

endpackage

[src/lob_if.sv]
// Valid/ready channel interface carrying one payload type.
// Depends on lob_pkg only through the payload type given by the user.
interface lob_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/limit_order_book_unit.sv]
// Top level of the limit order book: controller and datapath.
// Depends on lob_pkg, lob_if, lob_ctrl and lob_datapath.
//
// Price-time priority order book with MAX_ORDERS slots. For each command,
// one pass over the slot memory, one slot a cycle through its single read
// port, finds the id, the first free slot and the best bid and ask; the
// command is committed; a second pass finds the best prices of the updated
// book. The next transaction is accepted in the cycle its predecessor's
// result is taken. The slot memory needs no clearing pass; valid bits reset
// at once.
module limit_order_book_unit import lob_pkg::*; #(
  parameter int MAX_ORDERS = MAX_ORDERS_DEFAULT
) (
  input logic clk,
  input logic rst,
  lob_if.sink   in_ch,
  lob_if.source out_ch
);
  lob_cmd_t  ctl;
  lob_stat_t stat;

  lob_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  lob_datapath #(.MAX_ORDERS(MAX_ORDERS)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .stat    (stat),
    .in_item (in_ch.data),
    .result  (out_ch.data)
  );
endmodule

[src/lob_datapath.sv]
// Slot memory, slot scanner and running totals of the order book.
// Depends on lob_pkg.
module lob_datapath import lob_pkg::*; #(
  parameter int MAX_ORDERS = MAX_ORDERS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  lob_cmd_t  ctl,
  output lob_stat_t stat,
  input  lob_in_t   in_item,
  output lob_out_t  result
);
  localparam int AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;

  // Slot record memory; valid bits live in flops.
  typedef struct packed {
    logic [31:0] id;
    logic        side;
    logic [31:0] price;
    logic [31:0] remaining;
    logic [47:0] seq;
  } slot_t;

  slot_t                  mem [MAX_ORDERS];
  logic [MAX_ORDERS-1:0]  slot_valid;
  slot_t                  rd;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          ex_addr;
  logic                   ex_valid;

  lob_in_t     cur;
  logic [47:0] seq_counter;
  logic [39:0] bid_total;
  logic [39:0] ask_total;

  // Scan results.
  logic          match_found;
  logic [AW-1:0] match_addr;
  slot_t         match_rec;
  logic          free_found;
  logic [AW-1:0] free_addr;
  logic          bb_found, ba_found;
  slot_t         bb_rec, ba_rec;
  logic [AW-1:0] bb_addr, ba_addr;

  logic bb_better, ba_better;

  always_ff @(posedge clk) begin
    rd <= mem[rd_addr];
  end

  // Read address leads the examine stage; the memory read is registered in between.
  always_comb begin
    rd_addr = ex_addr;
    if (ctl.scan_start) begin
      rd_addr = '0;
    end else if (ctl.scan_step) begin
      rd_addr = ex_addr + AW'(1);
    end
  end

  assign stat.scan_last = (ex_addr == AW'(MAX_ORDERS - 1));

  always_comb begin
    bb_better = !bb_found || (rd.price > bb_rec.price) ||
                (rd.price == bb_rec.price && rd.seq < bb_rec.seq);
    ba_better = !ba_found || (rd.price < ba_rec.price) ||
                (rd.price == ba_rec.price && rd.seq < ba_rec.seq);
  end

  assign ex_valid = slot_valid[ex_addr];

  // Commit decode.
  logic        do_place, do_drop;
  logic [AW-1:0] place_addr, drop_addr;
  logic        place_side;
  slot_t       drop_rec;
  logic [2:0]  st;
  logic        pop_hit;
  logic [47:0] seq_next;

  always_comb begin
    do_place   = 1'b0;
    do_drop    = 1'b0;
    place_addr = free_addr;
    drop_addr  = match_addr;
    drop_rec   = match_rec;
    place_side = cur.side;
    st         = ST_OK;
    pop_hit    = 1'b0;
    unique case (cur.cmd)
      CMD_ADD: begin
        if (match_found) begin
          st = ST_DUP;
        end else if (!free_found) begin
          st = ST_FULL;
        end else begin
          do_place = 1'b1;
        end
      end
      CMD_CANCEL, CMD_MODIFY: begin
        if (!match_found) begin
          st = ST_NOT_FOUND;
        end else begin
          do_drop    = 1'b1;
          do_place   = (cur.cmd == CMD_MODIFY);
          place_addr = match_addr;
          place_side = match_rec.side;
        end
      end
      CMD_POP: begin
        if (cur.side ? !bb_found : !ba_found) begin
          st = ST_EMPTY;
        end else begin
          do_drop   = 1'b1;
          pop_hit   = 1'b1;
          drop_addr = cur.side ? bb_addr : ba_addr;
          drop_rec  = cur.side ? bb_rec : ba_rec;
        end
      end
      default: begin
      end
    endcase
    seq_next = seq_counter + 48'd1;
  end

  logic [39:0] bid_next, ask_next;
  always_comb begin
    bid_next = bid_total;
    ask_next = ask_total;
    if (do_drop) begin
      if (drop_rec.side) ask_next = ask_next - {8'd0, drop_rec.remaining};
      else               bid_next = bid_next - {8'd0, drop_rec.remaining};
    end
    if (do_place) begin
      if (place_side) ask_next = ask_next + {8'd0, cur.quantity};
      else            bid_next = bid_next + {8'd0, cur.quantity};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && do_place) begin
      mem[place_addr] <= '{id: cur.order_id, side: place_side, price: cur.price,
                           remaining: cur.quantity, seq: seq_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      seq_counter <= '0;
      bid_total   <= '0;
      ask_total   <= '0;
      ex_addr     <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      bb_found    <= 1'b0;
      ba_found    <= 1'b0;
    end else begin
      if (ctl.scan_start) begin
        ex_addr     <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        bb_found    <= 1'b0;
        ba_found    <= 1'b0;
      end else if (ctl.scan_step) begin
        ex_addr <= ex_addr + AW'(1);
        if (ex_valid) begin
          if (!match_found && rd.id == cur.order_id) begin
            match_found <= 1'b0 | 1'b1;
            match_addr  <= ex_addr;
            match_rec   <= rd;
          end
          if (!rd.side && bb_better) begin
            bb_found <= 1'b1;
            bb_addr  <= ex_addr;
            bb_rec   <= rd;
          end
          if (rd.side && ba_better) begin
            ba_found <= 1'b1;
            ba_addr  <= ex_addr;
            ba_rec   <= rd;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_addr  <= ex_addr;
        end
      end
      if (ctl.commit) begin
        bid_total <= bid_next;
        ask_total <= ask_next;
        if (do_place) seq_counter <= seq_next;
        // A modify drops and places the same slot; the place wins.
        if (do_place)     slot_valid[place_addr] <= 1'b1;
        else if (do_drop) slot_valid[drop_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur <= in_item;
    end
    if (ctl.commit) begin
      result.status           <= st;
      result.popped_id        <= pop_hit ? drop_rec.id : 32'd0;
      result.popped_side      <= pop_hit ? drop_rec.side : 1'b0;
      result.popped_price     <= pop_hit ? drop_rec.price : 32'd0;
      result.popped_remaining <= pop_hit ? drop_rec.remaining : 32'd0;
      result.bid_volume       <= bid_next;
      result.ask_volume       <= ask_next;
    end
    // Report follows a second, quiet scan of the committed book.
    if (ctl.report) begin
      result.top_bid_valid <= bb_found;
      result.top_bid       <= bb_found ? bb_rec.price : 32'd0;
      result.top_ask_valid <= ba_found;
      result.top_ask       <= ba_found ? ba_rec.price : 32'd0;
    end
  end

`ifndef SYNTHESIS
  a_seq_on_place: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && do_place |=> seq_counter == $past(seq_counter) + 48'd1)
    else $error("sequence counter did not advance on place");
  a_seq_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.commit |=> $stable(seq_counter))
    else $error("sequence counter moved outside commit");
  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.commit |=> $stable(bid_total) && $stable(ask_total))
    else $error("totals moved outside commit");
`endif
endmodule

[src/lob_ctrl.sv]
// Sequencer for the order book: accept, scan, commit, rescan, report.
// Depends on lob_pkg.
module lob_ctrl import lob_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output lob_cmd_t  ctl,
  input  lob_stat_t stat
);
  typedef enum logic [2:0] {
    S_IDLE, S_PRIME1, S_SCAN1, S_COMMIT, S_PRIME2, S_SCAN2, S_REPORT, S_HOLD
  } state_t;
  state_t state;

  // Accept a new transaction while idle, or while the result is taken.
  assign in_ready = (state == S_IDLE) || (state == S_HOLD && out_ready);

  always_comb begin
    ctl            = '0;
    ctl.load       = in_valid && in_ready;
    ctl.scan_start = ctl.load || state == S_COMMIT;
    ctl.scan_step  = state == S_SCAN1 || state == S_SCAN2;
    ctl.commit     = state == S_COMMIT;
    ctl.report     = state == S_REPORT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_PRIME1;
        S_PRIME1: state <= S_SCAN1;
        S_SCAN1:  if (stat.scan_last) state <= S_COMMIT;
        S_COMMIT: state <= S_PRIME2;
        S_PRIME2: state <= S_SCAN2;
        S_SCAN2:  if (stat.scan_last) state <= S_REPORT;
        S_REPORT: begin
          state     <= S_HOLD;
          out_valid <= 1'b1;
        end
        S_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= in_valid ? S_PRIME1 : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_valid_in_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_HOLD)
    else $error("result shown outside hold");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(ctl.commit && ctl.scan_step))
    else $error("commit overlaps scan");
  a_report_then_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.report |=> out_valid)
    else $error("report did not raise valid");
`endif
endmodule
